@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/lqwd_pkg.sv @@
package lqwd_pkg;
   typedef struct packed {
      logic        op;
      logic [2:0]  queue_number;
      logic [15:0] exec_time;
      logic [15:0] task_tag;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] result_tag;
      logic [3:0]  worker_number;
      logic [31:0] start_second;
      logic        last;
   } rsp_word_type;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DROP  = 1'b1;
   localparam int   MAX_RESULTS = 8;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_ARRIVE, CMD_FREE, CMD_SCAN, CMD_READ, CMD_START, CMD_ADVANCE
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } cmd_type;

   typedef struct packed {
      logic found;   // a free worker and a non-empty queue both exist
      logic full;    // arrival target queue full or out of range
   } status_type;
endpackage

@@ rtl/lqwd_datapath.sv @@
module lqwd_datapath #(
   parameter int NUM_QUEUES  = 8,
   parameter int NUM_WORKERS = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lqwd_pkg::cmd_type     cmd,
   input  lqwd_pkg::req_word_type req_word,
   input  logic [3:0]            workers_in_use,
   input  logic                  rsp_last,
   output lqwd_pkg::status_type  status,
   output lqwd_pkg::rsp_word_type rsp_word
);
   import lqwd_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
   localparam int DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = $clog2(NUM_WORKERS + 1);
   localparam int AW = QW + DW;
   localparam int SW = DW + 1;

   logic [31:0]   second_ff;
   logic          busy_ff [NUM_WORKERS];
   logic [31:0]   deadline_ff [NUM_WORKERS];
   logic [31:0]   served_ff [NUM_QUEUES];
   logic [DW-1:0] head_ff [NUM_QUEUES];
   logic [FW-1:0] fill_ff [NUM_QUEUES];
   logic [31:0]   mem [NUM_QUEUES * QUEUE_DEPTH];
   logic [31:0]   rd_ff;
   logic [QW-1:0] q_ff;
   logic [WW-1:0] w_ff;
   logic          found_ff;

   logic [LW-1:0] limit;
   logic [QW-1:0] q_in;
   logic [WW-1:0] w_in;
   logic          qok, wok;
   logic [SW-1:0] slot_sum;
   logic [DW-1:0] slot;
   logic          full;
   logic [QW-1:0] aq;

   assign limit = (32'(workers_in_use) > NUM_WORKERS) ? LW'(NUM_WORKERS) : LW'(workers_in_use);

   // Priority scans over workers and queues; registered before use.
   always_comb begin
      wok = 1'b0;
      w_in = '0;
      for (int w = NUM_WORKERS - 1; w >= 0; w--) begin
         if (LW'(w) < limit && !busy_ff[w]) begin
            wok = 1'b1;
            w_in = WW'(w);
         end
      end
      qok = 1'b0;
      q_in = '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (fill_ff[q] != '0 && (!qok || served_ff[q] < served_ff[q_in])) begin
            qok = 1'b1;
            q_in = QW'(q);
         end
      end
   end

   assign aq = QW'(req_word.queue_number);
   assign full = (32'(req_word.queue_number) >= NUM_QUEUES) || (fill_ff[aq] >= FW'(QUEUE_DEPTH));
   // Head plus fill stays below twice the depth, so one subtraction wraps it.
   assign slot_sum = SW'(head_ff[aq]) + SW'(fill_ff[aq]);
   assign slot = (slot_sum >= SW'(QUEUE_DEPTH)) ? DW'(slot_sum - SW'(QUEUE_DEPTH))
                                                : DW'(slot_sum);
   assign status.found = found_ff;
   assign status.full = full;

   always_ff @(posedge clock) begin
      if (cmd.code == CMD_ARRIVE && !full)
         mem[AW'(aq) * AW'(QUEUE_DEPTH) + AW'(slot)] <= {req_word.task_tag, req_word.exec_time};
      if (cmd.code == CMD_READ)
         rd_ff <= mem[AW'(q_ff) * AW'(QUEUE_DEPTH) + AW'(head_ff[q_ff])];
      if (cmd.code == CMD_SCAN) begin
         q_ff <= q_in;
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 32'd1;
         found_ff <= 1'b0;
         for (int i = 0; i < NUM_WORKERS; i++) begin
            busy_ff[i] <= 1'b0;
            deadline_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_QUEUES; i++) begin
            served_ff[i] <= '0;
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         case (cmd.code)
            CMD_ARRIVE: begin
               if (!full) fill_ff[aq] <= fill_ff[aq] + 1'b1;
            end
            CMD_FREE: begin
               for (int i = 0; i < NUM_WORKERS; i++) begin
                  if (busy_ff[i] && deadline_ff[i] == second_ff) begin
                     busy_ff[i] <= 1'b0;
                     deadline_ff[i] <= '0;
                  end
               end
            end
            CMD_SCAN: found_ff <= wok && qok;
            CMD_START: begin
               head_ff[q_ff] <= (32'(head_ff[q_ff]) == QUEUE_DEPTH - 1) ? '0
                                                                        : head_ff[q_ff] + 1'b1;
               fill_ff[q_ff] <= fill_ff[q_ff] - 1'b1;
               served_ff[q_ff] <= second_ff;
               busy_ff[w_ff] <= 1'b1;
               deadline_ff[w_ff] <= second_ff + 32'(rd_ff[15:0]);
            end
            CMD_ADVANCE: second_ff <= second_ff + 32'd1;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_word = '0;
      rsp_word.last = rsp_last;
      if (cmd.code == CMD_START) begin
         rsp_word.kind = KIND_START;
         rsp_word.result_tag = rd_ff[31:16];
         rsp_word.worker_number = 4'(w_ff) + 4'd1;
         rsp_word.start_second = second_ff;
      end else begin
         rsp_word.kind = KIND_DROP;
         rsp_word.result_tag = req_word.task_tag;
      end
   end
endmodule

@@ rtl/lqwd_control.sv @@
module lqwd_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lqwd_pkg::req_word_type req_word,
   input  lqwd_pkg::status_type  status,
   output logic                  busy,
   output lqwd_pkg::cmd_type     cmd,
   output logic                  rsp_valid,
   output logic                  rsp_last,
   output lqwd_pkg::req_word_type held_word
);
   import lqwd_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_FREE, S_SCAN, S_TEST, S_READ, S_START, S_DONE}
      state_type;

   state_type state_ff;
   logic [3:0] count_ff;
   req_word_type word_ff;

   assign busy = (state_ff != S_IDLE);
   assign held_word = (state_ff == S_IDLE) ? req_word : word_ff;

   always_comb begin
      cmd.code = CMD_NONE;
      rsp_valid = 1'b0;
      rsp_last = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && req_word.op == OP_ARRIVAL) begin
               cmd.code = CMD_ARRIVE;
               rsp_valid = status.full;
               rsp_last = 1'b1;
            end
         end
         S_FREE: cmd.code = CMD_FREE;
         S_SCAN: cmd.code = CMD_SCAN;
         S_READ: cmd.code = CMD_READ;
         S_START: begin
            cmd.code = CMD_START;
            rsp_valid = 1'b1;
         end
         S_DONE: cmd.code = CMD_ADVANCE;
         default: ;
      endcase
   end

   // The last flag of a start needs to know whether another start follows, so
   // each start is held back until the next scan decides; see top level.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start && req_word.op == OP_TICK) begin
                  word_ff <= req_word;
                  count_ff <= '0;
                  state_ff <= S_FREE;
               end
            end
            S_FREE: state_ff <= S_SCAN;
            S_SCAN: state_ff <= S_TEST;
            S_TEST: state_ff <= (status.found && count_ff < 4'(MAX_RESULTS)) ? S_READ : S_DONE;
            S_READ: state_ff <= S_START;
            S_START: begin
               count_ff <= count_ff + 4'd1;
               state_ff <= S_SCAN;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/lqwd_outreg.sv @@
module lqwd_outreg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_last,
   input  logic                   flush,
   input  lqwd_pkg::rsp_word_type in_word,
   output logic                   rsp_strobe,
   output lqwd_pkg::rsp_word_type rsp_word
);
   import lqwd_pkg::*;

   // One-deep hold for a start word until the next decision marks it last or not.
   logic         hold_ff;
   rsp_word_type hword_ff;
   logic         strobe_ff;
   rsp_word_type oword_ff;
   rsp_word_type flush_word;

   always_comb begin
      flush_word = hword_ff;
      flush_word.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (in_valid && in_last) begin
            strobe_ff <= 1'b1;
            oword_ff <= in_word;
         end else if (in_valid) begin
            if (hold_ff) begin
               strobe_ff <= 1'b1;
               oword_ff <= hword_ff;
            end
            hold_ff <= 1'b1;
            hword_ff <= in_word;
         end else if (flush && hold_ff) begin
            strobe_ff <= 1'b1;
            oword_ff <= flush_word;
            hold_ff <= 1'b0;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word = oword_ff;
endmodule

@@ rtl/lru_queue_worker_dispatcher.sv @@
// Dispatcher of tasks from per-queue FIFOs onto a pool of workers. An arrival
// word (start high while busy low) is stored in its queue; a full queue
// yields a drop word on the cycle after. A tick frees due workers, then for
// each started task scans workers and queues, tests the result, reads the
// FIFO memory and starts the task, and ends with a final scan and test and
// the second advance; a tick starts at most eight tasks. Result words appear
// for one cycle each on rsp_strobe and cannot be stalled; the last word of a
// tick appears in the cycle after the second advance.
module lru_queue_worker_dispatcher #(
   parameter int NUM_QUEUES  = 8,
   parameter int NUM_WORKERS = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lqwd_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output lqwd_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [3:0]             csr_data
);
   import lqwd_pkg::*;
   `include "assert_macros.svh"

   logic [3:0]   workers_ff;
   cmd_type      cmd;
   status_type   status;
   req_word_type held_word;
   rsp_word_type dp_word;
   logic         dp_valid, dp_last;
   logic         arrive_take, tick_take, drop_out;

   // The register is always writable; writing it only while idle is left to the user.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) workers_ff <= 4'd8;
      else if (csr_valid) workers_ff <= csr_data;
   end

   lqwd_control u_ctrl (
      .clock, .reset, .start, .req_word, .status, .busy, .cmd,
      .rsp_valid(dp_valid), .rsp_last(dp_last), .held_word
   );

   lqwd_datapath #(.NUM_QUEUES(NUM_QUEUES), .NUM_WORKERS(NUM_WORKERS),
                   .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock, .reset, .cmd, .req_word(held_word), .workers_in_use(workers_ff),
      .rsp_last(dp_last), .status, .rsp_word(dp_word)
   );

   // A start is held until the controller knows if another follows; the
   // advance command closes the tick and releases the held word as last.
   lqwd_outreg u_out (
      .clock, .reset, .in_valid(dp_valid), .in_last(dp_last),
      .flush(cmd.code == CMD_ADVANCE), .in_word(dp_word), .rsp_strobe, .rsp_word
   );

   assign arrive_take = start && !busy && req_word.op == OP_ARRIVAL;
   assign tick_take = start && !busy && req_word.op == OP_TICK;
   assign drop_out = rsp_strobe && rsp_word.kind == KIND_DROP;

   `ASSERT_NEXT(a_arrive_one_cycle, clock, reset, arrive_take, !busy)
   `ASSERT_NEXT(a_tick_goes_busy, clock, reset, tick_take, busy)
   `ASSERT_IMPLIES(a_drop_no_worker, clock, reset, drop_out, rsp_word.worker_number == 4'd0)
endmodule
